// ----- rtl/ndr_pkg.sv -----
// shared types and constants for the ntfs data run decoder
`default_nettype none

package ndr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ACC_W   = 64;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned LANES   = ACC_W / BYTE_W;
    localparam logic [3:0]  NIBBLE_MASK = 4'hF;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_OFFSET = 2'd2,
        PH_ENDED  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_RUN     = 2'd0,
        ST_END     = 2'd1,
        ST_BAD_LEN = 2'd2,
        ST_BAD_OFF = 2'd3
    } status_t;

    typedef struct packed {
        status_t            status;
        logic [CNT_W-1:0]   run_index;
        logic [ACC_W-1:0]   start_vcn;
        logic [ACC_W-1:0]   abs_lcn;
        logic [ACC_W-1:0]   run_length;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/ntfs_data_run_decoder.sv -----
// top level of the ntfs runlist data run decoder
//
// slave channel: one runlist byte per transaction, s_tuser marks the first
// byte of a new list and clears all decoding state before that byte.
// master channel: one result per finished run, end marker or size error;
// header, length and offset bytes that do not finish a run give none.
// the step logic updates the state at the accepting edge and the result
// lands in the output register at that same edge, so a result appears on
// the master side in the cycle after the byte that caused it.
// throughput is one byte per cycle; the only limit is the single output
// register, s_tready is low only while it holds a result that m_tready
// does not take in that cycle.
// while the receiver stalls the held result stays on the master side and
// no byte is taken. after reset the state is as at a list start and the
// output register is empty. after an end marker or an error bytes are
// consumed with no result until the next list start.
`default_nettype none

module ntfs_data_run_decoder
    import ndr_pkg::*;
#(
    parameter int unsigned MAX_FIELD_BYTES = 8
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,    // data_byte
    input  wire logic [0:0]     s_tuser,    // list_start
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [223:0]        m_tdata,    // run_index, start_vcn, abs_lcn, run_length
    output logic [1:0]          m_tuser     // status
);

    logic    in_accept;
    logic    res_valid;
    logic    can_load;
    result_t res;
    result_t out_res;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = can_load;

    ndr_core #(
        .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .data_byte (s_tdata),
        .list_start(s_tuser[0]),
        .res_valid (res_valid),
        .res       (res)
    );

    ndr_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (in_accept && res_valid),
        .load_data(res),
        .take     (m_tvalid && m_tready),
        .can_load (can_load),
        .out_valid(m_tvalid),
        .out_data (out_res)
    );

    assign m_tuser = out_res.status;
    assign m_tdata = {out_res.run_length, out_res.abs_lcn,
                      out_res.start_vcn, out_res.run_index};

endmodule

`default_nettype wire

// ----- rtl/ndr_core.sv -----
// decoding state and per-byte step logic of the data run decoder
`default_nettype none

module ndr_core
    import ndr_pkg::*;
#(
    parameter int unsigned MAX_FIELD_BYTES = 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_accept,
    input  wire logic [BYTE_W-1:0]  data_byte,
    input  wire logic               list_start,
    output logic                    res_valid,
    output result_t                 res
);

    phase_t             phase_reg, phase_next, e_phase;
    logic [3:0]         len_left_reg, len_left_next, e_len_left;
    logic [3:0]         off_left_reg, off_left_next, e_off_left;
    logic [3:0]         pos_reg, pos_next, e_pos;
    logic [ACC_W-1:0]   len_acc_reg, len_acc_next, e_len_acc;
    logic [ACC_W-1:0]   off_acc_reg, off_acc_next, e_off_acc;
    logic [ACC_W-1:0]   prev_lcn_reg, prev_lcn_next, e_prev_lcn;
    logic [ACC_W-1:0]   next_vcn_reg, next_vcn_next, e_next_vcn;
    logic [CNT_W-1:0]   run_cnt_reg, run_cnt_next, e_run_cnt;
    logic               err_reg, err_next, e_err;

    logic [3:0]         lo, hi, len_dec, off_dec;
    logic [ACC_W-1:0]   len_placed, off_placed, off_final, lcn_sum;
    logic               finish_len, finish_off;

    localparam logic [3:0] MAX_NIB = 4'(MAX_FIELD_BYTES);

    always_comb begin
        // a list start byte sees freshly cleared state
        if (list_start) begin
            e_phase    = PH_HEADER;
            e_len_left = '0;
            e_off_left = '0;
            e_pos      = '0;
            e_len_acc  = '0;
            e_off_acc  = '0;
            e_prev_lcn = '0;
            e_next_vcn = '0;
            e_run_cnt  = '0;
            e_err      = 1'b0;
        end else begin
            e_phase    = phase_reg;
            e_len_left = len_left_reg;
            e_off_left = off_left_reg;
            e_pos      = pos_reg;
            e_len_acc  = len_acc_reg;
            e_off_acc  = off_acc_reg;
            e_prev_lcn = prev_lcn_reg;
            e_next_vcn = next_vcn_reg;
            e_run_cnt  = run_cnt_reg;
            e_err      = err_reg;
        end

        lo      = data_byte[3:0] & NIBBLE_MASK;
        hi      = data_byte[7:4] & NIBBLE_MASK;
        len_dec = e_len_left - 4'd1;
        off_dec = e_off_left - 4'd1;

        len_placed = e_len_acc;
        off_placed = e_off_acc;
        for (int i = 0; i < LANES; i++) begin
            if (e_pos[2:0] == 3'(i)) begin
                len_placed[i*BYTE_W +: BYTE_W] = len_placed[i*BYTE_W +: BYTE_W] | data_byte;
                off_placed[i*BYTE_W +: BYTE_W] = off_placed[i*BYTE_W +: BYTE_W] | data_byte;
            end
        end
        // sign fill above the top offset byte
        off_final = off_placed;
        for (int j = 0; j < LANES; j++) begin
            if (data_byte[BYTE_W-1] && (4'(j) > e_pos)) begin
                off_final[j*BYTE_W +: BYTE_W] = '1;
            end
        end

        finish_len = 1'b0;
        finish_off = 1'b0;

        phase_next    = e_phase;
        len_left_next = e_len_left;
        off_left_next = e_off_left;
        pos_next      = e_pos;
        len_acc_next  = e_len_acc;
        off_acc_next  = e_off_acc;
        err_next      = e_err;

        res_valid      = 1'b0;
        res.status     = ST_RUN;
        res.run_index  = e_run_cnt;
        res.start_vcn  = '0;
        res.abs_lcn    = '0;
        res.run_length = '0;

        if (!e_err && e_phase != PH_ENDED) begin
            case (e_phase)
                PH_HEADER: begin
                    if (data_byte == '0) begin
                        phase_next    = PH_ENDED;
                        res_valid     = 1'b1;
                        res.status    = ST_END;
                        res.start_vcn = e_next_vcn;
                    end else if (lo == 4'd0 || lo > MAX_NIB) begin
                        err_next   = 1'b1;
                        res_valid  = 1'b1;
                        res.status = ST_BAD_LEN;
                    end else if (hi > MAX_NIB || (hi == 4'd0 && e_run_cnt == '0)) begin
                        err_next   = 1'b1;
                        res_valid  = 1'b1;
                        res.status = ST_BAD_OFF;
                    end else begin
                        len_left_next = lo;
                        off_left_next = hi;
                        pos_next      = '0;
                        len_acc_next  = '0;
                        off_acc_next  = '0;
                        phase_next    = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    len_acc_next  = len_placed;
                    len_left_next = len_dec;
                    pos_next      = e_pos + 4'd1;
                    if (len_dec == 4'd0) begin
                        pos_next = '0;
                        if (e_off_left == 4'd0) begin
                            finish_len = 1'b1;
                            phase_next = PH_HEADER;
                        end else begin
                            phase_next = PH_OFFSET;
                        end
                    end
                end
                PH_OFFSET: begin
                    off_acc_next  = off_placed;
                    off_left_next = off_dec;
                    pos_next      = e_pos + 4'd1;
                    if (off_dec == 4'd0) begin
                        off_acc_next = off_final;
                        finish_off   = 1'b1;
                        phase_next   = PH_HEADER;
                        pos_next     = '0;
                    end
                end
                default: begin
                    phase_next = e_phase;
                end
            endcase
        end

        // run completion: the only place that moves lcn, vcn and the count
        if (finish_len) begin
            lcn_sum      = e_prev_lcn + e_off_acc;
            len_acc_next = len_placed;
        end else begin
            lcn_sum = e_prev_lcn + off_final;
        end

        prev_lcn_next = e_prev_lcn;
        next_vcn_next = e_next_vcn;
        run_cnt_next  = e_run_cnt;
        if (finish_len || finish_off) begin
            prev_lcn_next  = lcn_sum;
            next_vcn_next  = e_next_vcn + len_acc_next;
            run_cnt_next   = e_run_cnt + CNT_W'(1);
            res_valid      = 1'b1;
            res.status     = ST_RUN;
            res.start_vcn  = e_next_vcn;
            res.abs_lcn    = lcn_sum;
            res.run_length = len_acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            len_left_reg <= '0;
            off_left_reg <= '0;
            pos_reg      <= '0;
            len_acc_reg  <= '0;
            off_acc_reg  <= '0;
            prev_lcn_reg <= '0;
            next_vcn_reg <= '0;
            run_cnt_reg  <= '0;
            err_reg      <= 1'b0;
        end else if (in_accept) begin
            phase_reg    <= phase_next;
            len_left_reg <= len_left_next;
            off_left_reg <= off_left_next;
            pos_reg      <= pos_next;
            len_acc_reg  <= len_acc_next;
            off_acc_reg  <= off_acc_next;
            prev_lcn_reg <= prev_lcn_next;
            next_vcn_reg <= next_vcn_next;
            run_cnt_reg  <= run_cnt_next;
            err_reg      <= err_next;
        end
    end

    // an ended list never carries a latched error
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(err_reg && phase_reg == PH_ENDED))
        else $error("ndr_core: error latched in ended phase");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_LENGTH) |-> (len_left_reg != 4'd0))
        else $error("ndr_core: length phase with no bytes left");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_OFFSET) |-> (off_left_reg != 4'd0))
        else $error("ndr_core: offset phase with no bytes left");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg < 4'(LANES))
        else $error("ndr_core: byte position out of range");

endmodule

`default_nettype wire

// ----- rtl/ndr_out_reg.sv -----
// result register between the decode step and the master channel
`default_nettype none

module ndr_out_reg
    import ndr_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     load,
    input  wire result_t  load_data,
    input  wire logic     take,
    output logic          can_load,
    output logic          out_valid,
    output result_t       out_data
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    // a slot frees up in the same cycle its transaction completes
    assign can_load = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire
